// ===== rtl/assert_macros.svh =====
// Assertion shorthands; clocked on clk, off while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/gccd_pkg.sv =====
package gccd_pkg;

	localparam int DEF_X_BINS       = 16;
	localparam int DEF_Y_BINS       = 16;
	localparam int DEF_TIME_BINS    = 64;
	localparam int DEF_SLICE_STRIDE = 4;

	localparam int COORD_W   = 32;
	localparam int ACC_W     = 24;
	localparam int CNT_W     = 6;
	// quotient bits left once the saturation case is split off
	localparam int DIV_STEPS = 41;

	localparam logic [40:0] MAG_LIM_D   = 41'd1 << 40;
	localparam logic [32:0] MAG_LIM_OFF = 33'd1 << 32;
	localparam logic [41:0] MAG_LIM_Q   = 42'd1 << 41;

	typedef enum logic [1:0] {
		CMD_CLEAR   = 2'd0,
		CMD_DEPOSIT = 2'd1,
		CMD_READ    = 2'd2
	} cmd_t;

	typedef enum logic [2:0] {
		REG_WIN_X_LOW = 3'd0,
		REG_WIN_Y_LOW = 3'd1,
		REG_BIN_W_X   = 3'd2,
		REG_BIN_W_Y   = 3'd3,
		REG_INV_W_X   = 3'd4,
		REG_INV_W_Y   = 3'd5,
		REG_HALF_X    = 3'd6,
		REG_HALF_Y    = 3'd7
	} reg_idx_t;

	typedef enum logic [1:0] {
		BS_START,
		BS_END,
		BS_OTHER
	} bin_sel_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_READ,
		ST_REJ_MX,
		ST_REJ_MY,
		ST_REJ_CHK,
		ST_AX_INIT,
		ST_BN_LO,
		ST_BN_HI,
		ST_BN_FIN,
		ST_LOOP,
		ST_LN_ADD,
		ST_PR_LO,
		ST_PR_HI,
		ST_PR_SUM,
		ST_DIV_CHK,
		ST_DIV,
		ST_OTHER,
		ST_ACC_RD,
		ST_ACC_WR,
		ST_FINISH
	} state_t;

endpackage

// ===== rtl/grid_crossing_current_deposit_core.sv =====
// Grid-crossing current deposit engine.
// Commands: start with command/fields while busy is low launches one request.
//   clear   : zeroes all accumulators, one entry per cycle (2*2^XW*2^YW*2^TW
//             entries, 32768 at default sizes), then one result.
//   read    : returns one 24-bit accumulator.
//   deposit : window/half-cell rejection, then two sweeps (x lines, y lines).
//             In each sweep the shared 41x16 multiplier forms bins, line
//             positions and offset products, and a radix-2 divider (41 steps)
//             gives the crossing point. Each hit is a read-modify-write.
// Results: done pulses for one cycle with read_value, crossings_added and
//   segment_rejected; the receiver cannot stall, so nothing is held back.
//   busy drops in the cycle done is high, so a new request may follow at once.
// Config: cfg_we/cfg_index/cfg_data write one register per cycle, no wait;
//   write only while busy is low and no result is pending.
// Reset: arst_n clears control and restores register defaults, then a
//   clearing pass over the store runs with busy high; it gives no result.
`include "assert_macros.svh"

module grid_crossing_current_deposit_core #(
	parameter int X_BINS       = gccd_pkg::DEF_X_BINS,
	parameter int Y_BINS       = gccd_pkg::DEF_Y_BINS,
	parameter int TIME_BINS    = gccd_pkg::DEF_TIME_BINS,
	parameter int SLICE_STRIDE = gccd_pkg::DEF_SLICE_STRIDE
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         command,
	input  logic signed [31:0] start_x,
	input  logic signed [31:0] start_y,
	input  logic signed [31:0] end_x,
	input  logic signed [31:0] end_y,
	input  logic signed [3:0]  particle_charge,
	input  logic [7:0]         time_slice,
	input  logic               read_component,
	input  logic [3:0]         read_x_bin,
	input  logic [3:0]         read_y_bin,
	input  logic [5:0]         read_time_bin,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	output logic               done,
	output logic signed [23:0] read_value,
	output logic [5:0]         crossings_added,
	output logic               segment_rejected
);
	import gccd_pkg::*;

	localparam int XW = (X_BINS > 1) ? $clog2(X_BINS) : 1;
	localparam int YW = (Y_BINS > 1) ? $clog2(Y_BINS) : 1;
	localparam int TW = (TIME_BINS > 1) ? $clog2(TIME_BINS) : 1;
	localparam int AW = 1 + XW + YW + TW;
	localparam int MEM_DEPTH = 2 ** AW;
	localparam int MAXB = (X_BINS > Y_BINS) ? X_BINS : Y_BINS;
	// signed bin index: one spare for the clamp value BINS, one for sign
	localparam int IW = $clog2(MAXB + 1) + 1;
	// time_slice / SLICE_STRIDE as multiply by reciprocal; exact for 8-bit slices
	localparam int SLICE_RECIP = (65536 + SLICE_STRIDE - 1) / SLICE_STRIDE;

	// |v| saturated at 2^40 (bin index operand)
	function automatic logic [40:0] sat_mag(input logic [44:0] v);
		logic [44:0] m;
		m = v[44] ? (~v + 45'd1) : v;
		sat_mag = (m > {4'd0, MAG_LIM_D}) ? MAG_LIM_D : m[40:0];
	endfunction

	state_t state_q, state_d;

	// configuration
	logic signed [31:0] win_x_low_q, win_y_low_q;
	logic [30:0]        bin_w_x_q, bin_w_y_q, half_x_q, half_y_q;
	logic [31:0]        inv_x_q, inv_y_q;

	// request
	logic [1:0]         cmd_q;
	logic signed [31:0] sx_q, sy_q, ex_q, ey_q;
	logic signed [3:0]  charge_q;
	logic [7:0]         tbin_q;
	logic [AW-1:0]      rd_addr_q;
	logic               rd_ok_q;

	// clearing pass
	logic [AW-1:0] clr_cnt_q;
	logic          clr_reply_q;

	// sweep datapath
	logic signed [41:0]   xhi_q;
	logic                 comp_q, dir_neg_q, db_neg_q, da_zero_q;
	logic [30:0]          dam_q, dbm_q;
	logic [40:0]          bin_a_q, tmp_q;
	logic                 bin_neg_q;
	bin_sel_t             bsel_q;
	logic [56:0]          mul_q;
	logic signed [IW-1:0] ib_q, jb_q, i_q, ob_q;
	logic [32:0]          mo_q;
	logic                 q_neg_q, q_sat_q;
	logic [63:0]          prod_q;
	logic [30:0]          rem_q;
	logic [40:0]          num_q;
	logic [5:0]           div_cnt_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 rej_q;

	// store
	logic [ACC_W-1:0]        acc_mem_q [MEM_DEPTH];
	logic signed [ACC_W-1:0] mem_rd_q;

	// results
	logic                    done_q, rejected_q;
	logic signed [ACC_W-1:0] read_value_q;
	logic [CNT_W-1:0]        crossings_q;

	// axis view: "a" is the swept axis, "b" the other one
	logic [31:0]          as_w, ae_w, bs_w, alow_w, blow_w, ainv_w, binv_w, inv_w;
	logic [30:0]          awid_w;
	logic signed [IW-1:0] an_w, bn_w;
	logic [32:0]          dx_w, dy_w, dxm_w, dym_w, da_w, db_w, dam_w, dbm_w;
	logic [44:0]          d_start_w, d_end_w, off_w, off_m_w, other_w, d_other_w;
	logic [41:0]          qv_w, p_w;
	logic [57:0]          bsum_w;
	logic [IW-1:0]        clamp_w, i_inc_w, i_step_w;
	logic                 ob_ok_w, loop_go_w;
	logic [31:0]          rem2_w;
	logic                 ge_w;
	logic [4:0]           delta_w;
	logic [24:0]          acc_sum_w;
	logic [ACC_W-1:0]     acc_sat_w;
	logic [AW-1:0]        acc_addr_w;
	logic [24:0]          tprod_w;
	logic                 reject_w, tbin_ok_w;
	logic signed [41:0]   yhi_w;

	// shared unit and store port
	logic [40:0]      mul_a_w;
	logic [15:0]      mul_b_w;
	logic             mem_we_w;
	logic [AW-1:0]    mem_addr_w;
	logic [ACC_W-1:0] mem_wdata_w;

	assign as_w   = comp_q ? sy_q : sx_q;
	assign ae_w   = comp_q ? ey_q : ex_q;
	assign bs_w   = comp_q ? sx_q : sy_q;
	assign alow_w = comp_q ? win_y_low_q : win_x_low_q;
	assign blow_w = comp_q ? win_x_low_q : win_y_low_q;
	assign awid_w = comp_q ? bin_w_y_q : bin_w_x_q;
	assign ainv_w = comp_q ? inv_y_q : inv_x_q;
	assign binv_w = comp_q ? inv_x_q : inv_y_q;
	assign an_w   = comp_q ? IW'(Y_BINS) : IW'(X_BINS);
	assign bn_w   = comp_q ? IW'(X_BINS) : IW'(Y_BINS);
	assign inv_w  = (bsel_q == BS_OTHER) ? binv_w : ainv_w;

	assign dx_w  = {ex_q[31], ex_q} - {sx_q[31], sx_q};
	assign dy_w  = {ey_q[31], ey_q} - {sy_q[31], sy_q};
	assign dxm_w = dx_w[32] ? (~dx_w + 33'd1) : dx_w;
	assign dym_w = dy_w[32] ? (~dy_w + 33'd1) : dy_w;
	assign da_w  = comp_q ? dy_w : dx_w;
	assign db_w  = comp_q ? dx_w : dy_w;
	assign dam_w = comp_q ? dym_w : dxm_w;
	assign dbm_w = comp_q ? dxm_w : dym_w;

	assign d_start_w = {{13{as_w[31]}}, as_w} - {{13{alow_w[31]}}, alow_w};
	assign d_end_w   = {{13{ae_w[31]}}, ae_w} - {{13{alow_w[31]}}, alow_w};

	// offset of line i+1 from the segment start; mul_q holds (i+1)*width
	assign off_w   = {{13{alow_w[31]}}, alow_w} + {4'd0, mul_q[40:0]}
	               - {{13{as_w[31]}}, as_w};
	assign off_m_w = off_w[44] ? (~off_w + 45'd1) : off_w;

	// crossing coordinate on the other axis, relative to its window edge
	assign qv_w      = q_sat_q ? MAG_LIM_Q : {1'b0, num_q};
	assign other_w   = {{13{bs_w[31]}}, bs_w}
	                 + (q_neg_q ? (~{3'd0, qv_w} + 45'd1) : {3'd0, qv_w});
	assign d_other_w = other_w - {{13{blow_w[31]}}, blow_w};

	// bin index magnitude: (a*inv_hi + (a*inv_lo >> 16)) >> 16
	assign bsum_w = {1'b0, mul_q} + {17'd0, tmp_q};
	assign p_w    = bsum_w[57:16];
	always_comb begin
		if (bin_neg_q && (p_w != '0)) begin
			clamp_w = '0;
		end else if (p_w >= 42'(an_w)) begin
			clamp_w = an_w;
		end else begin
			clamp_w = p_w[IW-1:0];
		end
	end
	assign ob_ok_w = (!bin_neg_q || (p_w == '0)) && (p_w < 42'(bn_w));

	assign loop_go_w = dir_neg_q ? (i_q > jb_q) : (i_q < jb_q);
	assign i_inc_w   = i_q + IW'(1);
	assign i_step_w  = dir_neg_q ? (i_q - IW'(1)) : i_inc_w;

	// one restoring division step
	assign rem2_w = {rem_q, num_q[40]};
	assign ge_w   = rem2_w >= {1'b0, dam_q};

	// saturating accumulate of +-charge
	assign delta_w   = dir_neg_q ? (~{charge_q[3], charge_q} + 5'd1) : {charge_q[3], charge_q};
	assign acc_sum_w = {mem_rd_q[23], mem_rd_q} + {{20{delta_w[4]}}, delta_w};
	always_comb begin
		if (acc_sum_w[24] != acc_sum_w[23]) begin
			acc_sat_w = acc_sum_w[24] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
		end else begin
			acc_sat_w = acc_sum_w[23:0];
		end
	end

	assign acc_addr_w = comp_q
		? {1'b1, ob_q[XW-1:0], i_q[YW-1:0], TW'(tbin_q)}
		: {1'b0, i_q[XW-1:0], ob_q[YW-1:0], TW'(tbin_q)};

	assign tprod_w = {17'd0, time_slice} * 25'(SLICE_RECIP);

	// window and step-length rejection
	assign yhi_w = $signed({{10{win_y_low_q[31]}}, win_y_low_q}) + $signed({1'b0, mul_q[40:0]});
	assign reject_w =
		((sx_q < win_x_low_q) && (ex_q < win_x_low_q)) ||
		(($signed({{10{sx_q[31]}}, sx_q}) > xhi_q) && ($signed({{10{ex_q[31]}}, ex_q}) > xhi_q)) ||
		((sy_q < win_y_low_q) && (ey_q < win_y_low_q)) ||
		(($signed({{10{sy_q[31]}}, sy_q}) > yhi_w) && ($signed({{10{ey_q[31]}}, ey_q}) > yhi_w)) ||
		(dxm_w > {2'd0, half_x_q}) || (dym_w > {2'd0, half_y_q});
	assign tbin_ok_w = 16'(tbin_q) < 16'(TIME_BINS);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		mul_a_w     = '0;
		mul_b_w     = '0;
		mem_we_w    = 1'b0;
		mem_addr_w  = acc_addr_w;
		mem_wdata_w = acc_sat_w;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					case (command)
						CMD_CLEAR:   state_d = ST_CLEAR;
						CMD_DEPOSIT: state_d = ST_REJ_MX;
						CMD_READ:    state_d = ST_READ;
						default:     state_d = ST_FINISH;
					endcase
				end
			end
			ST_CLEAR: begin
				mem_we_w    = 1'b1;
				mem_addr_w  = clr_cnt_q;
				mem_wdata_w = '0;
				if (&clr_cnt_q) begin
					state_d = clr_reply_q ? ST_FINISH : ST_IDLE;
				end
			end
			ST_READ: begin
				mem_addr_w = rd_addr_q;
				state_d    = ST_FINISH;
			end
			ST_REJ_MX: begin
				mul_a_w = 41'(bin_w_x_q);
				mul_b_w = 16'(X_BINS);
				state_d = ST_REJ_MY;
			end
			ST_REJ_MY: begin
				mul_a_w = 41'(bin_w_y_q);
				mul_b_w = 16'(Y_BINS);
				state_d = ST_REJ_CHK;
			end
			ST_REJ_CHK: begin
				state_d = (reject_w || !tbin_ok_w) ? ST_FINISH : ST_AX_INIT;
			end
			ST_AX_INIT: state_d = ST_BN_LO;
			ST_BN_LO: begin
				mul_a_w = bin_a_q;
				mul_b_w = inv_w[15:0];
				state_d = ST_BN_HI;
			end
			ST_BN_HI: begin
				mul_a_w = bin_a_q;
				mul_b_w = inv_w[31:16];
				state_d = ST_BN_FIN;
			end
			ST_BN_FIN: begin
				case (bsel_q)
					BS_START: state_d = ST_BN_LO;
					BS_END: begin
						if ((ib_q == $signed(clamp_w)) || da_zero_q) begin
							state_d = comp_q ? ST_FINISH : ST_AX_INIT;
						end else begin
							state_d = ST_LOOP;
						end
					end
					default: state_d = ob_ok_w ? ST_ACC_RD : ST_LOOP;
				endcase
			end
			ST_LOOP: begin
				mul_a_w = 41'(awid_w);
				mul_b_w = 16'(i_inc_w);
				if (loop_go_w) begin
					state_d = ST_LN_ADD;
				end else begin
					state_d = comp_q ? ST_FINISH : ST_AX_INIT;
				end
			end
			ST_LN_ADD: state_d = ST_PR_LO;
			ST_PR_LO: begin
				mul_a_w = 41'(mo_q);
				mul_b_w = dbm_q[15:0];
				state_d = ST_PR_HI;
			end
			ST_PR_HI: begin
				mul_a_w = 41'(mo_q);
				mul_b_w = 16'(dbm_q[30:16]);
				state_d = ST_PR_SUM;
			end
			ST_PR_SUM: state_d = ST_DIV_CHK;
			ST_DIV_CHK: begin
				state_d = ({8'd0, prod_q} >= {dam_q, 41'd0}) ? ST_OTHER : ST_DIV;
			end
			ST_DIV: begin
				if (div_cnt_q == 6'(DIV_STEPS - 1)) begin
					state_d = ST_OTHER;
				end
			end
			ST_OTHER:  state_d = ST_BN_LO;
			ST_ACC_RD: state_d = ST_ACC_WR;
			ST_ACC_WR: begin
				mem_we_w = 1'b1;
				state_d  = ST_LOOP;
			end
			ST_FINISH: state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// control registers and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q   <= '0;
			clr_reply_q <= 1'b0;
			done_q      <= 1'b0;
			win_x_low_q <= '0;
			win_y_low_q <= '0;
			bin_w_x_q   <= 31'd65536;
			bin_w_y_q   <= 31'd65536;
			inv_x_q     <= 32'd65536;
			inv_y_q     <= 32'd65536;
			half_x_q    <= 31'h7FFF_FFFF;
			half_y_q    <= 31'h7FFF_FFFF;
		end else begin
			done_q <= (state_q == ST_FINISH);
			if (state_q == ST_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + AW'(1);
			end
			if ((state_q == ST_IDLE) && start) begin
				clr_reply_q <= (command == CMD_CLEAR);
				clr_cnt_q   <= '0;
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_WIN_X_LOW: win_x_low_q <= cfg_data;
					REG_WIN_Y_LOW: win_y_low_q <= cfg_data;
					REG_BIN_W_X:   bin_w_x_q   <= cfg_data[30:0];
					REG_BIN_W_Y:   bin_w_y_q   <= cfg_data[30:0];
					REG_INV_W_X:   inv_x_q     <= cfg_data;
					REG_INV_W_Y:   inv_y_q     <= cfg_data;
					REG_HALF_X:    half_x_q    <= cfg_data[30:0];
					REG_HALF_Y:    half_y_q    <= cfg_data[30:0];
					default:       ;
				endcase
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		mul_q <= mul_a_w * mul_b_w;
		if (state_d == ST_AX_INIT) begin
			comp_q <= (state_q != ST_REJ_CHK);
		end
		case (state_q)
			ST_IDLE: begin
				cmd_q     <= command;
				sx_q      <= start_x;
				sy_q      <= start_y;
				ex_q      <= end_x;
				ey_q      <= end_y;
				charge_q  <= particle_charge;
				tbin_q    <= tprod_w[23:16];
				rd_addr_q <= {read_component, XW'(read_x_bin), YW'(read_y_bin),
				              TW'(read_time_bin)};
				rd_ok_q   <= (16'(read_x_bin) < 16'(X_BINS)) && (16'(read_y_bin) < 16'(Y_BINS))
				          && (16'(read_time_bin) < 16'(TIME_BINS));
				cnt_q     <= '0;
				rej_q     <= 1'b0;
			end
			ST_REJ_MY: begin
				xhi_q <= $signed({{10{win_x_low_q[31]}}, win_x_low_q})
				       + $signed({1'b0, mul_q[40:0]});
			end
			ST_REJ_CHK: rej_q <= reject_w;
			ST_AX_INIT: begin
				dam_q     <= dam_w[30:0];
				dbm_q     <= dbm_w[30:0];
				dir_neg_q <= da_w[32];
				db_neg_q  <= db_w[32];
				da_zero_q <= (da_w == '0);
				bin_a_q   <= sat_mag(d_start_w);
				bin_neg_q <= d_start_w[44];
				bsel_q    <= BS_START;
			end
			ST_BN_HI: tmp_q <= mul_q[56:16];
			ST_BN_FIN: begin
				case (bsel_q)
					BS_START: begin
						ib_q      <= clamp_w;
						bin_a_q   <= sat_mag(d_end_w);
						bin_neg_q <= d_end_w[44];
						bsel_q    <= BS_END;
					end
					BS_END: begin
						i_q  <= dir_neg_q ? (ib_q - IW'(1)) : ib_q;
						jb_q <= dir_neg_q ? ($signed(clamp_w) - IW'(1)) : clamp_w;
					end
					default: begin
						ob_q <= p_w[IW-1:0];
						if (!ob_ok_w) begin
							i_q <= i_step_w;
						end
					end
				endcase
			end
			ST_LN_ADD: begin
				mo_q    <= (off_m_w > {12'd0, MAG_LIM_OFF}) ? MAG_LIM_OFF : off_m_w[32:0];
				q_neg_q <= off_w[44] ^ db_neg_q ^ dir_neg_q;
			end
			ST_PR_HI:  prod_q <= 64'(mul_q);
			ST_PR_SUM: prod_q <= prod_q + {mul_q[47:0], 16'd0};
			ST_DIV_CHK: begin
				q_sat_q   <= ({8'd0, prod_q} >= {dam_q, 41'd0});
				rem_q     <= {8'd0, prod_q[63:41]};
				num_q     <= prod_q[40:0];
				div_cnt_q <= '0;
			end
			ST_DIV: begin
				rem_q     <= ge_w ? 31'(rem2_w - {1'b0, dam_q}) : rem2_w[30:0];
				num_q     <= {num_q[39:0], ge_w};
				div_cnt_q <= div_cnt_q + 6'd1;
			end
			ST_OTHER: begin
				bin_a_q   <= sat_mag(d_other_w);
				bin_neg_q <= d_other_w[44];
				bsel_q    <= BS_OTHER;
			end
			ST_ACC_WR: begin
				i_q <= i_step_w;
				if (cnt_q != '1) begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
			end
			ST_FINISH: begin
				read_value_q <= ((cmd_q == CMD_READ) && rd_ok_q) ? mem_rd_q : '0;
				crossings_q  <= cnt_q;
				rejected_q   <= rej_q;
			end
			default: ;
		endcase
	end

	// accumulator store: one port, registered read
	always_ff @(posedge clk) begin
		if (mem_we_w) begin
			acc_mem_q[mem_addr_w] <= mem_wdata_w;
		end
	end

	always_ff @(posedge clk) begin
		mem_rd_q <= acc_mem_q[mem_addr_w];
	end

	assign busy             = (state_q != ST_IDLE);
	assign done             = done_q;
	assign read_value       = read_value_q;
	assign crossings_added  = crossings_q;
	assign segment_rejected = rejected_q;

	`ASSERT_NEXT(a_accept_busy, start && !busy, busy, "request accepted but engine not busy")
	`ASSERT_IMPLIES(a_rej_clean, done && segment_rejected, (crossings_added == '0) && (read_value == '0), "rejected segment reported deposits")
	`ASSERT_IMPLIES(a_hit_in_grid, state_q == ST_ACC_WR, (i_q >= 0) && (i_q < an_w), "deposit line index outside grid")
	`ASSERT_IMPLIES(a_div_rem, state_q == ST_DIV, rem_q < dam_q, "divider remainder not below divisor")

endmodule
